@@ sv/aas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aas_pkg;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_ACK    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TAKE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_FALL   = 2'd1,
        KIND_HEAT   = 2'd2,
        KIND_MOTION = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE       = 3'd0,
        CFG_URGENT_ON      = 3'd1,
        CFG_URGENT_GAP     = 3'd2,
        CFG_URGENT_LAST_ON = 3'd3,
        CFG_URGENT_PAUSE   = 3'd4,
        CFG_CALM_ON        = 3'd5,
        CFG_CALM_GAP       = 3'd6,
        CFG_CALM_PAUSE     = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_COUNT = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned STEP_W    = 3;

    typedef logic [CFG_W-1:0]  t_cfg_word;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [STEP_W-1:0] t_step;

    // Power-on register values, in milliseconds.
    localparam t_cfg_word DEBOUNCE_RST       = 16'd50;
    localparam t_cfg_word URGENT_ON_RST      = 16'd120;
    localparam t_cfg_word URGENT_GAP_RST     = 16'd80;
    localparam t_cfg_word URGENT_LAST_ON_RST = 16'd180;
    localparam t_cfg_word URGENT_PAUSE_RST   = 16'd450;
    localparam t_cfg_word CALM_ON_RST        = 16'd120;
    localparam t_cfg_word CALM_GAP_RST       = 16'd350;
    localparam t_cfg_word CALM_PAUSE_RST     = 16'd1000;

    // Final step of each cadence before it wraps to step zero.
    localparam t_step URGENT_LAST_STEP = 3'd5;
    localparam t_step CALM_LAST_STEP   = 3'd3;

endpackage

`default_nettype wire

@@ sv/alarm_annunciator_sequencer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ------------------------------------------
// in        sink       i_in_valid / o_in_stall    opcode, time_ms, fall/motion/heat, button
// out       source     o_out_valid / i_out_stall  buzzer, active_kind, acked_kind, pulse
// cfg       sink       i_cfg_wr_en                i_cfg_index, i_cfg_data (no stall)
//
// Every request produces exactly one result. A request is captured in an input
// register, processed combinationally against the alarm state, and its result lands
// in an output register, so one request per cycle is sustained while the output is not
// stalled. The result is presented once the request moves from the input register into
// the output register, which a stalled output can hold off. The state update for a request
// happens in the same cycle as its result register loads, so the next request always
// sees the state it depends on. Reset is synchronous and active low; it restores the
// register defaults and clears all alarm, debounce and edge-detect state. A stalled
// output holds its result and, once the input register is also full, the input stalls.

module alarm_annunciator_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_time_ms,
    input  wire logic        i_fall_level,
    input  wire logic        i_motion_level,
    input  wire logic        i_heat_level,
    input  wire logic        i_button_raw,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_buzzer,
    output logic [1:0]       o_active_kind,
    output logic [1:0]       o_acked_kind,
    output logic             o_light_hold_pulse,

    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers, each read at its own fixed index.
    aas_pkg::t_cfg_word r_cfg [aas_pkg::CFG_COUNT];

    // Input register.
    logic                r_in_valid;
    logic [1:0]          r_in_opcode;
    aas_pkg::t_time      r_in_time;
    logic                r_in_fall;
    logic                r_in_motion;
    logic                r_in_heat;
    logic                r_in_raw;

    // Output register.
    logic                r_out_valid;
    logic                r_out_buzzer;
    aas_pkg::t_kind      r_out_active;
    aas_pkg::t_kind      r_out_acked;
    logic                r_out_pulse;

    // Alarm state.
    aas_pkg::t_kind      r_kind,         n_kind;
    aas_pkg::t_kind      r_acked,        n_acked;
    logic                r_btn_stable,   n_btn_stable;
    logic                r_btn_last,     n_btn_last;
    aas_pkg::t_time      r_btn_change,   n_btn_change;
    aas_pkg::t_step      r_step,         n_step;
    aas_pkg::t_time      r_elapsed,      n_elapsed;
    aas_pkg::t_time      r_prev_time,    n_prev_time;
    logic                r_prev_fall,    n_prev_fall;
    logic                r_prev_motion,  n_prev_motion;
    logic                r_prev_heat,    n_prev_heat;
    logic                r_levels_seen,  n_levels_seen;
    logic                r_fall_lock,    n_fall_lock;
    logic                r_buzzer,       n_buzzer;

    // Result of the request in the input register.
    aas_pkg::t_kind      res_acked;
    logic                res_pulse;

    logic                advance;

    // The processing stage moves whenever the output register is free or being drained.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;

    assign o_buzzer           = r_out_buzzer;
    assign o_active_kind      = r_out_active;
    assign o_acked_kind       = r_out_acked;
    assign o_light_hold_pulse = r_out_pulse;

    always_comb begin
        aas_pkg::t_time delta;
        aas_pkg::t_time change_time;
        aas_pkg::t_time new_elapsed;
        aas_pkg::t_time dur;
        aas_pkg::t_step s;
        aas_pkg::t_step last;
        logic           pf;
        logic           pm;
        logic           ph;
        logic           press;
        logic           on;
        logic           fall_rise;
        logic           motion_rise;
        logic           heat_rise;

        n_kind        = r_kind;
        n_acked       = r_acked;
        n_btn_stable  = r_btn_stable;
        n_btn_last    = r_btn_last;
        n_btn_change  = r_btn_change;
        n_step        = r_step;
        n_elapsed     = r_elapsed;
        n_prev_time   = r_prev_time;
        n_prev_fall   = r_prev_fall;
        n_prev_motion = r_prev_motion;
        n_prev_heat   = r_prev_heat;
        n_levels_seen = r_levels_seen;
        n_fall_lock   = r_fall_lock;
        n_buzzer      = r_buzzer;
        res_pulse     = 1'b0;
        res_acked     = r_acked;

        delta       = '0;
        change_time = r_btn_change;
        new_elapsed = '0;
        dur         = '0;
        s           = '0;
        last        = '0;
        pf          = 1'b0;
        pm          = 1'b0;
        ph          = 1'b0;
        press       = 1'b0;
        on          = 1'b0;
        fall_rise   = 1'b0;
        motion_rise = 1'b0;
        heat_rise   = 1'b0;

        unique case (aas_pkg::t_opcode'(r_in_opcode))
            aas_pkg::OP_UPDATE: begin
                // A stored time of zero means no time seen yet: elapsed counts as zero.
                delta       = (r_prev_time == '0) ? '0 : (r_in_time - r_prev_time);
                n_prev_time = r_in_time;

                // The first update takes its own levels as the previous ones.
                pf = r_levels_seen ? r_prev_fall   : r_in_fall;
                pm = r_levels_seen ? r_prev_motion : r_in_motion;
                ph = r_levels_seen ? r_prev_heat   : r_in_heat;
                n_levels_seen = 1'b1;

                if (!r_in_fall) begin
                    n_fall_lock = 1'b0;
                end

                // Button debounce.
                if (r_in_raw != r_btn_last) begin
                    n_btn_last   = r_in_raw;
                    change_time  = r_in_time;
                    n_btn_change = r_in_time;
                end
                if (((r_in_time - change_time) >=
                        {{(aas_pkg::TIME_W-aas_pkg::CFG_W){1'b0}}, r_cfg[aas_pkg::CFG_DEBOUNCE]})
                        && (r_btn_stable != r_in_raw)) begin
                    n_btn_stable = r_in_raw;
                    press        = r_in_raw;
                end

                // A debounced press acknowledges the running alarm.
                if (press && (r_kind != aas_pkg::KIND_NONE)) begin
                    n_acked = r_kind;
                    if (r_kind == aas_pkg::KIND_FALL) begin
                        n_fall_lock = 1'b1;
                    end
                    n_kind    = aas_pkg::KIND_NONE;
                    n_step    = '0;
                    n_elapsed = '0;
                    n_buzzer  = 1'b0;
                end

                fall_rise   = r_in_fall   & ~pf;
                motion_rise = r_in_motion & ~pm;
                heat_rise   = r_in_heat   & ~ph;
                n_prev_fall   = r_in_fall;
                n_prev_motion = r_in_motion;
                n_prev_heat   = r_in_heat;

                // Fall preempts anything; a locked fall edge falls through to the others.
                priority if (fall_rise && !n_fall_lock) begin
                    if (n_kind != aas_pkg::KIND_FALL) begin
                        n_kind    = aas_pkg::KIND_FALL;
                        n_step    = '0;
                        n_elapsed = '0;
                    end
                end else if (heat_rise) begin
                    if (n_kind == aas_pkg::KIND_NONE) begin
                        n_kind    = aas_pkg::KIND_HEAT;
                        n_step    = '0;
                        n_elapsed = '0;
                    end
                end else if (motion_rise) begin
                    if (n_kind == aas_pkg::KIND_NONE) begin
                        n_kind    = aas_pkg::KIND_MOTION;
                        n_step    = '0;
                        n_elapsed = '0;
                        res_pulse = 1'b1;
                    end
                end else begin
                    n_kind = n_kind;
                end

                // Cadence step table; unused step codes act as the final step.
                if (n_kind == aas_pkg::KIND_FALL) begin
                    last = aas_pkg::URGENT_LAST_STEP;
                    s    = (n_step > aas_pkg::URGENT_LAST_STEP) ? aas_pkg::URGENT_LAST_STEP
                                                                 : n_step;
                    unique case (s)
                        3'd0, 3'd2: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_URGENT_ON]};
                            on  = 1'b1;
                        end
                        3'd1, 3'd3: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_URGENT_GAP]};
                            on  = 1'b0;
                        end
                        3'd4: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_URGENT_LAST_ON]};
                            on  = 1'b1;
                        end
                        default: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_URGENT_PAUSE]};
                            on  = 1'b0;
                        end
                    endcase
                end else begin
                    last = aas_pkg::CALM_LAST_STEP;
                    s    = (n_step > aas_pkg::CALM_LAST_STEP) ? aas_pkg::CALM_LAST_STEP
                                                               : n_step;
                    unique case (s)
                        3'd0, 3'd2: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_CALM_ON]};
                            on  = 1'b1;
                        end
                        3'd1: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_CALM_GAP]};
                            on  = 1'b0;
                        end
                        default: begin
                            dur = {16'd0, r_cfg[aas_pkg::CFG_CALM_PAUSE]};
                            on  = 1'b0;
                        end
                    endcase
                end
                new_elapsed = n_elapsed + delta;

                if (((n_kind == aas_pkg::KIND_FALL) && !r_in_fall)
                        || ((n_kind == aas_pkg::KIND_HEAT) && !r_in_heat)) begin
                    // Fall and temperature alarms end when their level drops.
                    n_kind    = aas_pkg::KIND_NONE;
                    n_step    = '0;
                    n_elapsed = '0;
                    n_buzzer  = 1'b0;
                end else if (n_kind == aas_pkg::KIND_NONE) begin
                    n_buzzer = 1'b0;
                end else begin
                    n_buzzer = on;
                    if (new_elapsed >= dur) begin
                        n_elapsed = '0;
                        n_step    = (s >= last) ? '0 : (s + 3'd1);
                    end else begin
                        n_elapsed = new_elapsed;
                        n_step    = s;
                    end
                end
                res_acked = n_acked;
            end
            aas_pkg::OP_ACK: begin
                if (r_kind != aas_pkg::KIND_NONE) begin
                    n_acked = r_kind;
                    if (r_kind == aas_pkg::KIND_FALL) begin
                        n_fall_lock = 1'b1;
                    end
                    n_kind    = aas_pkg::KIND_NONE;
                    n_step    = '0;
                    n_elapsed = '0;
                    n_buzzer  = 1'b0;
                end
                res_acked = n_acked;
            end
            aas_pkg::OP_CLEAR: begin
                n_kind      = aas_pkg::KIND_NONE;
                n_step      = '0;
                n_elapsed   = '0;
                n_buzzer    = 1'b0;
                n_acked     = aas_pkg::KIND_NONE;
                n_fall_lock = 1'b0;
                res_acked   = aas_pkg::KIND_NONE;
            end
            aas_pkg::OP_TAKE: begin
                // The result reports the latched type before it is cleared.
                res_acked = r_acked;
                n_acked   = aas_pkg::KIND_NONE;
            end
            default: begin
                res_acked = r_acked;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[aas_pkg::CFG_DEBOUNCE]       <= aas_pkg::DEBOUNCE_RST;
            r_cfg[aas_pkg::CFG_URGENT_ON]      <= aas_pkg::URGENT_ON_RST;
            r_cfg[aas_pkg::CFG_URGENT_GAP]     <= aas_pkg::URGENT_GAP_RST;
            r_cfg[aas_pkg::CFG_URGENT_LAST_ON] <= aas_pkg::URGENT_LAST_ON_RST;
            r_cfg[aas_pkg::CFG_URGENT_PAUSE]   <= aas_pkg::URGENT_PAUSE_RST;
            r_cfg[aas_pkg::CFG_CALM_ON]        <= aas_pkg::CALM_ON_RST;
            r_cfg[aas_pkg::CFG_CALM_GAP]       <= aas_pkg::CALM_GAP_RST;
            r_cfg[aas_pkg::CFG_CALM_PAUSE]     <= aas_pkg::CALM_PAUSE_RST;
        end else if (i_cfg_wr_en) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Input register: refills whenever it is empty or its request moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_opcode <= i_opcode;
            r_in_time   <= i_time_ms;
            r_in_fall   <= i_fall_level;
            r_in_motion <= i_motion_level;
            r_in_heat   <= i_heat_level;
            r_in_raw    <= i_button_raw;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_buzzer <= n_buzzer;
            r_out_active <= n_kind;
            r_out_acked  <= res_acked;
            r_out_pulse  <= res_pulse;
        end
    end

    // Alarm state commits together with the result of the request that changed it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= aas_pkg::KIND_NONE;
            r_acked       <= aas_pkg::KIND_NONE;
            r_btn_stable  <= 1'b0;
            r_btn_last    <= 1'b0;
            r_btn_change  <= '0;
            r_step        <= '0;
            r_elapsed     <= '0;
            r_prev_time   <= '0;
            r_prev_fall   <= 1'b0;
            r_prev_motion <= 1'b0;
            r_prev_heat   <= 1'b0;
            r_levels_seen <= 1'b0;
            r_fall_lock   <= 1'b0;
            r_buzzer      <= 1'b0;
        end else if (advance) begin
            r_kind        <= n_kind;
            r_acked       <= n_acked;
            r_btn_stable  <= n_btn_stable;
            r_btn_last    <= n_btn_last;
            r_btn_change  <= n_btn_change;
            r_step        <= n_step;
            r_elapsed     <= n_elapsed;
            r_prev_time   <= n_prev_time;
            r_prev_fall   <= n_prev_fall;
            r_prev_motion <= n_prev_motion;
            r_prev_heat   <= n_prev_heat;
            r_levels_seen <= n_levels_seen;
            r_fall_lock   <= n_fall_lock;
            r_buzzer      <= n_buzzer;
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import aas_pkg::*;

    typedef struct packed {
        logic  buzzer;
        t_kind active;
        t_kind acked;
        logic  pulse;
    } t_annunciation;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;

    logic      in_valid = 1'b0;
    wire       in_stall;
    t_opcode   in_opcode = OP_UPDATE;
    t_time     in_stamp = '0;
    logic      in_fall = 1'b0;
    logic      in_motion = 1'b0;
    logic      in_heat = 1'b0;
    logic      in_button = 1'b0;

    wire       out_valid;
    logic      out_stall = 1'b0;
    wire       out_buzzer;
    wire [1:0] out_active;
    wire [1:0] out_acked;
    wire       out_pulse;

    logic      cfg_wr_en = 1'b0;
    t_cfg_idx  cfg_index = CFG_DEBOUNCE;
    t_cfg_word cfg_data = '0;

    alarm_annunciator_sequencer_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_opcode           (in_opcode),
        .i_time_ms          (in_stamp),
        .i_fall_level       (in_fall),
        .i_motion_level     (in_motion),
        .i_heat_level       (in_heat),
        .i_button_raw       (in_button),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_buzzer           (out_buzzer),
        .o_active_kind      (out_active),
        .o_acked_kind       (out_acked),
        .o_light_hold_pulse (out_pulse),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Annunciator state as the block should hold it.
    t_cfg_word timing [CFG_COUNT];
    t_kind     alarm_now;
    t_kind     acked_now;
    logic      btn_stable;
    logic      btn_last;
    t_time     btn_change_at;
    t_step     step_now;
    t_time     step_ms;
    t_time     last_stamp;
    logic      last_fall;
    logic      last_motion;
    logic      last_heat;
    logic      levels_known;
    logic      fall_lock;
    logic      buzzer_now;

    t_annunciation annunciations_due [$];

    // Traffic generator state: a wall clock and the levels it is presenting.
    t_time clock_ms = 32'd1000;
    logic  lv_fall = 1'b0;
    logic  lv_motion = 1'b0;
    logic  lv_heat = 1'b0;
    logic  lv_button = 1'b0;
    int    btn_hold = 0;

    logic  idle_enabled = 1'b1;
    int    hold_off = 0;
    int    stall_left = 0;

    int    requests_sent = 0;
    int    results_seen = 0;
    int    mismatches = 0;
    int    stalled_cycles = 0;
    int    settings_applied = 0;
    int    fall_results = 0;
    int    heat_results = 0;
    int    motion_results = 0;
    int    pulses_seen = 0;

    function automatic void reset_annunciator();
        timing[CFG_DEBOUNCE]       = DEBOUNCE_RST;
        timing[CFG_URGENT_ON]      = URGENT_ON_RST;
        timing[CFG_URGENT_GAP]     = URGENT_GAP_RST;
        timing[CFG_URGENT_LAST_ON] = URGENT_LAST_ON_RST;
        timing[CFG_URGENT_PAUSE]   = URGENT_PAUSE_RST;
        timing[CFG_CALM_ON]        = CALM_ON_RST;
        timing[CFG_CALM_GAP]       = CALM_GAP_RST;
        timing[CFG_CALM_PAUSE]     = CALM_PAUSE_RST;
        alarm_now     = KIND_NONE;
        acked_now     = KIND_NONE;
        btn_stable    = 1'b0;
        btn_last      = 1'b0;
        btn_change_at = '0;
        step_now      = '0;
        step_ms       = '0;
        last_stamp    = '0;
        last_fall     = 1'b0;
        last_motion   = 1'b0;
        last_heat     = 1'b0;
        levels_known  = 1'b0;
        fall_lock     = 1'b0;
        buzzer_now    = 1'b0;
    endfunction

    function automatic void silence_alarm();
        alarm_now  = KIND_NONE;
        step_now   = '0;
        step_ms    = '0;
        buzzer_now = 1'b0;
    endfunction

    function automatic void raise_alarm(t_kind kind);
        if (alarm_now != kind) begin
            alarm_now = kind;
            step_now  = '0;
            step_ms   = '0;
        end
    endfunction

    function automatic void acknowledge_alarm();
        if (alarm_now != KIND_NONE) begin
            acked_now = alarm_now;
            if (alarm_now == KIND_FALL)
                fall_lock = 1'b1;
            silence_alarm();
        end
    endfunction

    // One timestamped update; returns the light-hold pulse.
    function automatic logic advance_annunciator(t_time stamp, logic fall, logic motion,
                                                 logic heat, logic raw);
        t_time     delta;
        t_time     held;
        t_cfg_word dur;
        t_step     last_step;
        logic      tone;
        logic      fall_rise;
        logic      motion_rise;
        logic      heat_rise;
        logic      pulse;
        pulse = 1'b0;
        // A stored time of zero means no time has been seen, so no time elapses.
        if (last_stamp == '0)
            last_stamp = stamp;
        delta      = stamp - last_stamp;
        last_stamp = stamp;
        if (!levels_known) begin
            last_fall    = fall;
            last_motion  = motion;
            last_heat    = heat;
            levels_known = 1'b1;
        end
        if (!fall)
            fall_lock = 1'b0;

        if (raw != btn_last) begin
            btn_last      = raw;
            btn_change_at = stamp;
        end
        held = stamp - btn_change_at;
        if (held >= {16'd0, timing[CFG_DEBOUNCE]} && btn_stable != raw) begin
            btn_stable = raw;
            if (raw)
                acknowledge_alarm();
        end

        fall_rise   = fall & ~last_fall;
        motion_rise = motion & ~last_motion;
        heat_rise   = heat & ~last_heat;
        last_fall   = fall;
        last_motion = motion;
        last_heat   = heat;

        if (fall_rise && !fall_lock) begin
            raise_alarm(KIND_FALL);
        end else if (heat_rise) begin
            if (alarm_now == KIND_NONE)
                raise_alarm(KIND_HEAT);
        end else if (motion_rise) begin
            if (alarm_now == KIND_NONE) begin
                raise_alarm(KIND_MOTION);
                pulse = 1'b1;
            end
        end

        if ((alarm_now == KIND_FALL && !fall) || (alarm_now == KIND_HEAT && !heat)) begin
            silence_alarm();
            return pulse;
        end
        if (alarm_now == KIND_NONE) begin
            buzzer_now = 1'b0;
            return pulse;
        end

        step_ms = step_ms + delta;
        if (alarm_now == KIND_FALL) begin
            last_step = URGENT_LAST_STEP;
            if (step_now > URGENT_LAST_STEP)
                step_now = URGENT_LAST_STEP;
            case (step_now)
                3'd0, 3'd2: begin dur = timing[CFG_URGENT_ON];      tone = 1'b1; end
                3'd1, 3'd3: begin dur = timing[CFG_URGENT_GAP];     tone = 1'b0; end
                3'd4:       begin dur = timing[CFG_URGENT_LAST_ON]; tone = 1'b1; end
                default:    begin dur = timing[CFG_URGENT_PAUSE];   tone = 1'b0; end
            endcase
        end else begin
            last_step = CALM_LAST_STEP;
            if (step_now > CALM_LAST_STEP)
                step_now = CALM_LAST_STEP;
            case (step_now)
                3'd0, 3'd2: begin dur = timing[CFG_CALM_ON];    tone = 1'b1; end
                3'd1:       begin dur = timing[CFG_CALM_GAP];   tone = 1'b0; end
                default:    begin dur = timing[CFG_CALM_PAUSE]; tone = 1'b0; end
            endcase
        end
        buzzer_now = tone;
        if (step_ms >= {16'd0, dur}) begin
            step_ms  = '0;
            step_now = (step_now >= last_step) ? '0 : step_now + 3'd1;
        end
        return pulse;
    endfunction

    function automatic t_annunciation predict_annunciation(t_opcode op, t_time stamp,
                                                           logic fall, logic motion,
                                                           logic heat, logic raw);
        t_annunciation res;
        res.pulse = 1'b0;
        case (op)
            OP_UPDATE: begin
                res.pulse = advance_annunciator(stamp, fall, motion, heat, raw);
                res.acked = acked_now;
            end
            OP_ACK: begin
                acknowledge_alarm();
                res.acked = acked_now;
            end
            OP_CLEAR: begin
                silence_alarm();
                acked_now = KIND_NONE;
                fall_lock = 1'b0;
                res.acked = KIND_NONE;
            end
            default: begin
                // Take reports the latched type and then empties the latch.
                res.acked = acked_now;
                acked_now = KIND_NONE;
            end
        endcase
        res.buzzer = buzzer_now;
        res.active = alarm_now;
        return res;
    endfunction

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_time pick_delta();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 70)
            return $urandom_range(1, 150);
        if (roll < 94)
            return $urandom_range(151, 1200);
        if (roll < 99)
            return $urandom_range(1201, 70000);
        return $urandom;
    endfunction

    function automatic t_cfg_word pick_setting(int limit);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom_range(0, limit);
    endfunction

    task automatic send_request(t_opcode op, t_time stamp, logic fall, logic motion,
                                logic heat, logic raw);
        int gap;
        gap = idle_enabled ? pick_idle() : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        in_opcode = op;
        in_stamp  = stamp;
        in_fall   = fall;
        in_motion = motion;
        in_heat   = heat;
        in_button = raw;
        @(posedge clk);
        while (in_stall) begin
            stalled_cycles++;
            @(posedge clk);
        end
        annunciations_due.push_back(predict_annunciation(op, stamp, fall, motion, heat, raw));
        requests_sent++;
    endtask

    task automatic send_update(t_time stamp, logic fall, logic motion, logic heat,
                               logic raw);
        send_request(OP_UPDATE, stamp, fall, motion, heat, raw);
    endtask

    // Commands ignore the update fields, so those carry random values.
    task automatic send_command(t_opcode op);
        send_request(op, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (annunciations_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(t_cfg_idx idx, t_cfg_word value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_data    = value;
        timing[idx] = value;
    endtask

    task automatic program_timing(t_cfg_word debounce, t_cfg_word u_on, t_cfg_word u_gap,
                                  t_cfg_word u_last, t_cfg_word u_pause, t_cfg_word c_on,
                                  t_cfg_word c_gap, t_cfg_word c_pause);
        write_register(CFG_DEBOUNCE, debounce);
        write_register(CFG_URGENT_ON, u_on);
        write_register(CFG_URGENT_GAP, u_gap);
        write_register(CFG_URGENT_LAST_ON, u_last);
        write_register(CFG_URGENT_PAUSE, u_pause);
        write_register(CFG_CALM_ON, c_on);
        write_register(CFG_CALM_GAP, c_gap);
        write_register(CFG_CALM_PAUSE, c_pause);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        settings_applied++;
    endtask

    // Mostly plausible sensor traffic on a running clock, with a few commands
    // and a few fully random requests mixed in.
    task automatic run_traffic(int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            idle_enabled = ((n / 80) % 4) != 3;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_request(t_opcode'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1));
            end else if (roll < 13) begin
                send_command(t_opcode'($urandom_range(1, 3)));
            end else begin
                if ($urandom_range(0, 199) == 0)
                    clock_ms = '0;
                else
                    clock_ms = clock_ms + pick_delta();
                if ($urandom_range(0, 99) < 6)
                    lv_fall = !lv_fall;
                if ($urandom_range(0, 99) < 8)
                    lv_heat = !lv_heat;
                if ($urandom_range(0, 99) < 8)
                    lv_motion = !lv_motion;
                if (btn_hold > 0) begin
                    btn_hold--;
                end else if ($urandom_range(0, 99) < 15) begin
                    lv_button = !lv_button;
                    btn_hold  = $urandom_range(0, 10);
                end
                send_update(clock_ms, lv_fall, lv_motion, lv_heat, lv_button);
            end
        end
        idle_enabled = 1'b1;
    endtask

    // The first update sees a zero stored time and takes its levels as the
    // previous ones, so nothing starts even with every level high.
    task automatic test_first_levels();
        send_update(32'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        send_update(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
        send_update(32'd30, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_idle_commands();
        send_command(OP_ACK);
        send_command(OP_TAKE);
    endtask

    task automatic test_preemption();
        send_update(32'd40, 1'b0, 1'b0, 1'b1, 1'b0);
        send_update(32'd60, 1'b0, 1'b1, 1'b1, 1'b0);
        send_update(32'd80, 1'b1, 1'b1, 1'b1, 1'b0);
        send_update(32'd300, 1'b1, 1'b1, 1'b1, 1'b0);
        send_update(32'd310, 1'b1, 1'b1, 1'b1, 1'b0);
    endtask

    // A debounced press acknowledges the fall alarm, which then stays down
    // while the fall level is held.
    task automatic test_button_acknowledge();
        send_update(32'd320, 1'b1, 1'b1, 1'b1, 1'b1);
        send_update(32'd400, 1'b1, 1'b1, 1'b1, 1'b1);
        send_update(32'd410, 1'b1, 1'b1, 1'b1, 1'b1);
        send_command(OP_TAKE);
        send_command(OP_TAKE);
    endtask

    task automatic test_level_drop();
        send_update(32'd500, 1'b0, 1'b0, 1'b0, 1'b1);
        send_update(32'd510, 1'b0, 1'b0, 1'b1, 1'b0);
        send_update(32'd520, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Motion alarms pulse the light hold and outlive their level.
    task automatic test_motion_light_hold();
        send_update(32'd530, 1'b0, 1'b1, 1'b0, 1'b0);
        send_update(32'd540, 1'b0, 1'b0, 1'b0, 1'b0);
        send_command(OP_ACK);
        send_update(32'd550, 1'b0, 1'b1, 1'b0, 1'b0);
        send_command(OP_CLEAR);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        @(negedge clk);
        in_valid     = 1'b0;
        hold_off     = 300;
        idle_enabled = 1'b0;
        clock_ms     = 32'd2000;
        for (int n = 0; n < 40; n++) begin
            clock_ms = clock_ms + $urandom_range(0, 200);
            send_update(clock_ms, n[3], n[2], n[4], n[1]);
        end
        idle_enabled = 1'b1;
    endtask

    task automatic test_timing_sweep();
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: program_timing('0, '0, '0, '0, '0, '0, '0, '0);
                1: program_timing('1, '1, '1, '1, '1, '1, '1, '1);
                5: program_timing(DEBOUNCE_RST, URGENT_ON_RST, URGENT_GAP_RST,
                                  URGENT_LAST_ON_RST, URGENT_PAUSE_RST, CALM_ON_RST,
                                  CALM_GAP_RST, CALM_PAUSE_RST);
                default: program_timing(pick_setting(120), pick_setting(300), pick_setting(300),
                                        pick_setting(300), pick_setting(600),
                                        pick_setting(300), pick_setting(600),
                                        pick_setting(1500));
            endcase
            // Some phases start just short of the timestamp wrap.
            if ($urandom_range(0, 1) == 1)
                clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4000);
            run_traffic(330);
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall = 1'b0;
        end else if (hold_off > 0) begin
            out_stall = 1'b1;
            hold_off--;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
            if (idle_enabled)
                stall_left = pick_idle();
        end
    end

    always @(posedge clk) begin : check_results
        t_annunciation seen;
        t_annunciation want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            seen = {out_buzzer, out_active, out_acked, out_pulse};
            results_seen++;
            if (annunciations_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding: buzzer %b active %0d",
                             $time, seen.buzzer, seen.active);
            end else begin
                want = annunciations_due.pop_front();
                if (seen.buzzer !== want.buzzer || seen.active !== want.active ||
                    seen.acked !== want.acked || seen.pulse !== want.pulse) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result %0d expected/actual: buzzer %b/%b ",
                                  "active %0d/%0d acked %0d/%0d pulse %b/%b"},
                                 $time, results_seen, want.buzzer, seen.buzzer,
                                 want.active, seen.active, want.acked, seen.acked,
                                 want.pulse, seen.pulse);
                end
                case (want.active)
                    KIND_FALL:   fall_results++;
                    KIND_HEAT:   heat_results++;
                    KIND_MOTION: motion_results++;
                    default:     ;
                endcase
                if (want.pulse)
                    pulses_seen++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("alarm_annunciator_sequencer_top: mismatch");
        $finish;
    end

    initial begin
        reset_annunciator();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_first_levels();
        test_idle_commands();
        test_preemption();
        test_button_acknowledge();
        test_level_drop();
        test_motion_light_hold();
        test_backpressure();
        test_timing_sweep();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests under %0d timing settings, %0d results checked.",
                 requests_sent, settings_applied, results_seen);
        $display({"Alarm results fall %0d, heat %0d, motion %0d; %0d light-hold pulses; ",
                  "input stalled %0d cycles; %0d mismatches."},
                 fall_results, heat_results, motion_results, pulses_seen, stalled_cycles,
                 mismatches);
        if (mismatches == 0 && annunciations_due.size() == 0)
            $display("alarm_annunciator_sequencer_top: match");
        else
            $display("alarm_annunciator_sequencer_top: mismatch");
        $finish;
    end

endmodule
